/* rtl/memory_registration_cache_defines.svh */
// ----------------------------------------------------------------------------
// memory registration cache assertion macros
// property forms used by mrc_ctrl
// ----------------------------------------------------------------------------
`ifndef MEMORY_REGISTRATION_CACHE_DEFINES_SVH
`define MEMORY_REGISTRATION_CACHE_DEFINES_SVH

// same-cycle implication
`define MRC_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("mrc assertion failed");

// next-cycle implication
`define MRC_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("mrc assertion failed");

`endif

/* rtl/mrc_pkg.sv */
// ----------------------------------------------------------------------------
// mrc_pkg
// widths, defaults and codes of the memory registration cache
// ----------------------------------------------------------------------------
package mrc_pkg;

  localparam int ENTRIES_DEF   = 256;
  localparam int ADDR_BITS_DEF = 48;
  localparam int LEN_W         = 32;
  localparam int SLOT_W        = 8;
  localparam int USES_W        = 16;
  localparam int CFG_W         = 9;
  localparam int CNT_OUT_W     = 9;
  localparam int MODE_W        = 2;
  localparam int OUTC_W        = 4;

  localparam logic [MODE_W-1:0] MODE_REG  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REL  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FREE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RSV  = 2'd3;

  localparam logic [OUTC_W-1:0] OUTC_HIT       = 4'd0;
  localparam logic [OUTC_W-1:0] OUTC_SUB_HIT   = 4'd1;
  localparam logic [OUTC_W-1:0] OUTC_FILL      = 4'd2;
  localparam logic [OUTC_W-1:0] OUTC_REPLACE   = 4'd3;
  localparam logic [OUTC_W-1:0] OUTC_UNCACHED  = 4'd4;
  localparam logic [OUTC_W-1:0] OUTC_RELEASED  = 4'd5;
  localparam logic [OUTC_W-1:0] OUTC_UNC_REL   = 4'd6;
  localparam logic [OUTC_W-1:0] OUTC_FREE_DONE = 4'd7;
  localparam logic [OUTC_W-1:0] OUTC_UNDERFLOW = 4'd8;

endpackage

/* rtl/mrc_ifs.sv */
// ----------------------------------------------------------------------------
// mrc channel interfaces
// request, response and configuration channels with valid/ready
// ----------------------------------------------------------------------------
interface mrc_req_if import mrc_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [ADDR_BITS-1:0] address;
  logic [LEN_W-1:0]     length;
  logic [SLOT_W-1:0]    slot;
  logic                 handle_cached;

  modport source (output valid, mode, address, length, slot, handle_cached, input ready);
  modport sink (input valid, mode, address, length, slot, handle_cached, output ready);
endinterface

interface mrc_rsp_if import mrc_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [OUTC_W-1:0]    outcome;
  logic [SLOT_W-1:0]    slot_out;
  logic [LEN_W-1:0]     sub_offset;
  logic                 evict_valid;
  logic [ADDR_BITS-1:0] evicted_start;
  logic [ADDR_BITS-1:0] evicted_end;
  logic [CNT_OUT_W-1:0] invalidated_count;
  logic [CNT_OUT_W-1:0] busy_count;

  modport source (output valid, outcome, slot_out, sub_offset, evict_valid, evicted_start,
                  evicted_end, invalidated_count, busy_count, input ready);
  modport sink (input valid, outcome, slot_out, sub_offset, evict_valid, evicted_start,
                evicted_end, invalidated_count, busy_count, output ready);
endinterface

interface mrc_cfg_if import mrc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* rtl/mrc_mem.sv */
// ----------------------------------------------------------------------------
// mrc_mem
// region table storage, one write and one registered read port
// ----------------------------------------------------------------------------
module mrc_mem import mrc_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int DATA_W  = 2 * ADDR_BITS_DEF + USES_W,
  localparam int IDX_W  = $clog2(ENTRIES)
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [IDX_W-1:0]  rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [IDX_W-1:0]  wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i
);

  logic [DATA_W-1:0] mem [ENTRIES];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/mrc_ctrl.sv */
// ----------------------------------------------------------------------------
// mrc_ctrl
// table walk, lookup decisions, valid bits and response register
// ----------------------------------------------------------------------------
`include "memory_registration_cache_defines.svh"

module mrc_ctrl import mrc_pkg::*; #(
  parameter int ENTRIES   = ENTRIES_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  localparam int IDX_W    = $clog2(ENTRIES),
  localparam int CNT_W    = $clog2(ENTRIES + 1),
  localparam int DATA_W   = 2 * ADDR_BITS + USES_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CNT_W-1:0]  n_i,
  mrc_req_if.sink           req,
  mrc_rsp_if.source         rsp,
  output logic              rd_en_o,
  output logic [IDX_W-1:0]  rd_addr_o,
  input  logic [DATA_W-1:0] rd_data_i,
  output logic              wr_en_o,
  output logic [IDX_W-1:0]  wr_addr_o,
  output logic [DATA_W-1:0] wr_data_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_REL, ST_FIN} state_e;

  state_e                state_q;
  logic [MODE_W-1:0]     mode_q;
  logic [ADDR_BITS-1:0]  addr_q, end_q;
  logic [SLOT_W-1:0]     slot_q;
  logic                  cached_q;
  logic [CNT_W-1:0]      rd_idx_q;
  logic                  chk_q;
  logic [IDX_W-1:0]      chk_idx_q;
  logic [ENTRIES-1:0]    valid_q;
  logic                  hit_q, emp_q, zero_q;
  logic [IDX_W-1:0]      hit_idx_q, emp_idx_q, zero_idx_q;
  logic [ADDR_BITS-1:0]  hit_start_q, hit_end_q, zero_start_q, zero_end_q;
  logic [USES_W-1:0]     hit_uses_q;
  logic [CNT_W-1:0]      inv_q, busy_q;

  logic                  rsp_valid_q;
  logic [OUTC_W-1:0]     outc_q;
  logic [SLOT_W-1:0]     slot_out_q;
  logic [LEN_W-1:0]      sub_off_q;
  logic                  evict_q;
  logic [ADDR_BITS-1:0]  ev_start_q, ev_end_q;
  logic [CNT_OUT_W-1:0]  inv_out_q, busy_out_q;

  logic                  in_fire, issue, load;
  logic [ADDR_BITS:0]    end_sum;
  logic [ADDR_BITS-1:0]  in_end, d_start, d_end;
  logic [USES_W-1:0]     d_uses;
  logic                  d_valid, contain, overlap;
  logic [IDX_W-1:0]      rel_idx;
  logic                  rel_ok;
  logic [OUTC_W-1:0]     res_outc;
  logic [LEN_W-1:0]      res_off;
  logic                  res_evict, set_valid;
  logic [CNT_W:0]        cnt_sum;

  assign in_fire = req.valid && req.ready;
  assign req.ready = (state_q == ST_IDLE);
  assign end_sum = {1'b0, req.address} + {{(ADDR_BITS + 1 - LEN_W){1'b0}}, req.length};
  assign in_end = end_sum[ADDR_BITS] ? '1 : end_sum[ADDR_BITS-1:0];

  assign issue = (state_q == ST_SCAN) && (rd_idx_q < n_i);
  assign rd_en_o = issue || (in_fire && req.mode == MODE_REL);
  assign rd_addr_o = issue ? rd_idx_q[IDX_W-1:0] : IDX_W'(req.slot);

  assign {d_start, d_end, d_uses} = rd_data_i;
  assign d_valid = valid_q[chk_idx_q];
  assign contain = d_valid && (d_start <= addr_q) && (end_q <= d_end);
  assign overlap = d_valid && (addr_q < d_end) && (d_start < end_q);

  assign rel_idx = IDX_W'(slot_q);
  assign rel_ok = cached_q && (32'(slot_q) < 32'(n_i)) && valid_q[rel_idx];

  assign load = (state_q == ST_FIN) && (!rsp_valid_q || rsp.ready);

  always_comb begin
    res_outc  = OUTC_UNCACHED;
    res_off   = '0;
    res_evict = 1'b0;
    set_valid = 1'b0;
    wr_en_o   = 1'b0;
    wr_addr_o = hit_idx_q;
    wr_data_o = {addr_q, end_q, USES_W'(1)};
    case (mode_q)
      MODE_REG: begin
        if (hit_q) begin
          wr_en_o = 1'b1;
          wr_data_o = {hit_start_q, hit_end_q,
                       (&hit_uses_q) ? hit_uses_q : hit_uses_q + USES_W'(1)};
          if (addr_q != hit_start_q) begin
            res_outc = OUTC_SUB_HIT;
            res_off = LEN_W'(addr_q - hit_start_q);
          end else begin
            res_outc = OUTC_HIT;
          end
        end else if (emp_q) begin
          wr_en_o = 1'b1;
          wr_addr_o = emp_idx_q;
          set_valid = 1'b1;
          res_outc = OUTC_FILL;
        end else if (zero_q) begin
          wr_en_o = 1'b1;
          wr_addr_o = zero_idx_q;
          res_outc = OUTC_REPLACE;
          res_evict = 1'b1;
        end
      end
      MODE_REL: begin
        wr_addr_o = rel_idx;
        wr_data_o = {hit_start_q, hit_end_q, hit_uses_q - USES_W'(1)};
        if (!rel_ok) begin
          res_outc = OUTC_UNC_REL;
        end else if (hit_uses_q == '0) begin
          res_outc = OUTC_UNDERFLOW;
        end else begin
          wr_en_o = 1'b1;
          res_outc = OUTC_RELEASED;
        end
      end
      default: res_outc = OUTC_FREE_DONE;
    endcase
    wr_en_o = wr_en_o && load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
      rsp_valid_q <= 1'b0;
      chk_q <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      if (load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            mode_q <= req.mode;
            addr_q <= req.address;
            end_q <= in_end;
            slot_q <= req.slot;
            cached_q <= req.handle_cached;
            rd_idx_q <= '0;
            chk_q <= 1'b0;
            hit_q <= 1'b0;
            emp_q <= 1'b0;
            zero_q <= 1'b0;
            inv_q <= '0;
            busy_q <= '0;
            if (req.mode == MODE_REL) begin
              state_q <= ST_REL;
            end else if (req.mode == MODE_REG || req.mode == MODE_FREE) begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          chk_q <= issue;
          chk_idx_q <= rd_idx_q[IDX_W-1:0];
          if (issue) begin
            rd_idx_q <= rd_idx_q + CNT_W'(1);
          end
          if (chk_q) begin
            if (mode_q == MODE_REG) begin
              if (contain && !hit_q) begin
                hit_q <= 1'b1;
                hit_idx_q <= chk_idx_q;
                hit_start_q <= d_start;
                hit_end_q <= d_end;
                hit_uses_q <= d_uses;
              end
              if (!d_valid && !emp_q) begin
                emp_q <= 1'b1;
                emp_idx_q <= chk_idx_q;
              end
              if (d_valid && d_uses == '0 && !zero_q) begin
                zero_q <= 1'b1;
                zero_idx_q <= chk_idx_q;
                zero_start_q <= d_start;
                zero_end_q <= d_end;
              end
            end else if (overlap) begin
              if (d_uses == '0) begin
                valid_q[chk_idx_q] <= 1'b0;
                inv_q <= inv_q + CNT_W'(1);
              end else begin
                busy_q <= busy_q + CNT_W'(1);
              end
            end
          end
          if (!issue && !chk_q) begin
            state_q <= ST_FIN;
          end
        end
        ST_REL: begin
          hit_start_q <= d_start;
          hit_end_q <= d_end;
          hit_uses_q <= d_uses;
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (load) begin
            outc_q <= res_outc;
            sub_off_q <= res_off;
            evict_q <= res_evict;
            ev_start_q <= res_evict ? zero_start_q : '0;
            ev_end_q <= res_evict ? zero_end_q : '0;
            inv_out_q <= (mode_q == MODE_FREE) ? CNT_OUT_W'(inv_q) : '0;
            busy_out_q <= (mode_q == MODE_FREE) ? CNT_OUT_W'(busy_q) : '0;
            case (res_outc)
              OUTC_HIT, OUTC_SUB_HIT: slot_out_q <= SLOT_W'(hit_idx_q);
              OUTC_FILL: slot_out_q <= SLOT_W'(emp_idx_q);
              OUTC_REPLACE: slot_out_q <= SLOT_W'(zero_idx_q);
              OUTC_RELEASED, OUTC_UNC_REL, OUTC_UNDERFLOW: slot_out_q <= slot_q;
              default: slot_out_q <= '0;
            endcase
            if (set_valid) begin
              valid_q[emp_idx_q] <= 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp.valid = rsp_valid_q;
  assign rsp.outcome = outc_q;
  assign rsp.slot_out = slot_out_q;
  assign rsp.sub_offset = sub_off_q;
  assign rsp.evict_valid = evict_q;
  assign rsp.evicted_start = ev_start_q;
  assign rsp.evicted_end = ev_end_q;
  assign rsp.invalidated_count = inv_out_q;
  assign rsp.busy_count = busy_out_q;

  assign cnt_sum = {1'b0, inv_q} + {1'b0, busy_q};

  `MRC_ASSERT_NOW(a_wr_only_fin, wr_en_o, state_q == ST_FIN)
  `MRC_ASSERT_NOW(a_cnt_bound, state_q == ST_SCAN, cnt_sum <= {1'b0, n_i})
  `MRC_ASSERT_NEXT(a_busy_after_accept, in_fire && req.mode != MODE_RSV, state_q != ST_IDLE)

endmodule

/* rtl/memory_registration_cache.sv */
// ----------------------------------------------------------------------------
// memory_registration_cache
// table of registered address regions with use counts
// ----------------------------------------------------------------------------
// channels: req carries one transaction per command (register, release or
// free), rsp returns one transaction per command, cfg writes the number of
// active slots. A reserved mode code is accepted and gives no response.
// register and free walk the active slots through the table memory; release
// reads one slot. The walk over the single memory read port sets the rate;
// one command is in flight at a time.
// the response register holds a finished transaction while the receiver
// stalls; the next command waits in the final step until it is taken.
// reset clears all valid bits and sets the active slot count to the table
// size, at most 256; no clearing pass is needed. cfg is always ready.
// ----------------------------------------------------------------------------
module memory_registration_cache import mrc_pkg::*; #(
  parameter int ENTRIES   = ENTRIES_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mrc_cfg_if.sink   cfg_i,
  mrc_req_if.sink   req_i,
  mrc_rsp_if.source rsp_o
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int DATA_W = 2 * ADDR_BITS + USES_W;

  logic [CNT_W-1:0]  n_q, n_d;
  logic              rd_en, wr_en;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic [DATA_W-1:0] rd_data, wr_data;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    n_d = n_q;
    if (cfg_i.valid) begin
      if (cfg_i.data == '0) begin
        n_d = CNT_W'(1);
      end else if (32'(cfg_i.data) > ENTRIES) begin
        n_d = CNT_W'(ENTRIES);
      end else begin
        n_d = CNT_W'(cfg_i.data);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= (ENTRIES > 256) ? CNT_W'(256) : CNT_W'(ENTRIES);
    end else begin
      n_q <= n_d;
    end
  end

  mrc_ctrl #(
    .ENTRIES   (ENTRIES),
    .ADDR_BITS (ADDR_BITS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .n_i       (n_q),
    .req       (req_i),
    .rsp       (rsp_o),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data)
  );

  mrc_mem #(
    .ENTRIES (ENTRIES),
    .DATA_W  (DATA_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the memory registration cache: a directed table of
// commands followed by random register/release/free/reserved traffic, every response
// compared with an in-bench predictor of the region table
// ----------------------------------------------------------------------------
module tb;
  import mrc_pkg::*;

  localparam int NSLOT = 256;
  localparam logic [47:0] AMAX = 48'hFFFF_FFFF_FFFF;
  localparam int WATCHDOG = 4000;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [47:0]       address;
    logic [31:0]       length;
    logic [7:0]        slot;
    logic              handle_cached;
  } cmd_t;

  typedef struct packed {
    logic [OUTC_W-1:0]    outcome;
    logic [7:0]           slot_out;
    logic [31:0]          sub_offset;
    logic                 evict_valid;
    logic [47:0]          evicted_start;
    logic [47:0]          evicted_end;
    logic [CNT_OUT_W-1:0] invalidated_count;
    logic [CNT_OUT_W-1:0] busy_count;
  } rsp_t;

  typedef struct {
    cmd_t cmd;
    logic chk;
    rsp_t rsp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mrc_cfg_if cfg ();
  mrc_req_if req ();
  mrc_rsp_if rsp ();

  memory_registration_cache dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg.sink),
    .req_i (req.sink),
    .rsp_o (rsp.source)
  );

  // predicted table
  logic        tbl_valid [NSLOT];
  logic [47:0] tbl_start [NSLOT];
  logic [47:0] tbl_end   [NSLOT];
  logic [15:0] tbl_uses  [NSLOT];
  int unsigned slots_used;

  rsp_t pending_rsp[$];
  rsp_t typed_rsp[$];
  logic typed_chk[$];
  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(input string what, input rsp_t got, input rsp_t exp);
    $display("mismatch %s: got %h exp %h", what, got, exp);
    errors++;
  endtask

  function automatic rsp_t predict_table(input cmd_t c);
    rsp_t r;
    logic [48:0] sum;
    logic [47:0] e;
    int n;
    int inv;
    int busy;
    bit done;
    r = '0;
    sum = {1'b0, c.address} + {17'd0, c.length};
    e = sum[48] ? AMAX : sum[47:0];
    n = (slots_used < 1) ? 1 : (slots_used > NSLOT ? NSLOT : slots_used);
    done = 1'b0;
    case (c.mode)
      MODE_REG: begin
        for (int i = 0; i < n && !done; i++) begin
          if (tbl_valid[i] && tbl_start[i] <= c.address && e <= tbl_end[i]) begin
            if (tbl_uses[i] != 16'hFFFF) tbl_uses[i]++;
            r.slot_out = i[7:0];
            if (c.address != tbl_start[i]) begin
              r.outcome = OUTC_SUB_HIT;
              r.sub_offset = 32'(c.address - tbl_start[i]);
            end else begin
              r.outcome = OUTC_HIT;
            end
            done = 1'b1;
          end
        end
        for (int i = 0; i < n && !done; i++) begin
          if (!tbl_valid[i]) begin
            tbl_valid[i] = 1'b1;
            tbl_start[i] = c.address;
            tbl_end[i] = e;
            tbl_uses[i] = 16'd1;
            r.outcome = OUTC_FILL;
            r.slot_out = i[7:0];
            done = 1'b1;
          end
        end
        for (int i = 0; i < n && !done; i++) begin
          if (tbl_uses[i] == 16'd0) begin
            r.outcome = OUTC_REPLACE;
            r.slot_out = i[7:0];
            r.evict_valid = 1'b1;
            r.evicted_start = tbl_start[i];
            r.evicted_end = tbl_end[i];
            tbl_start[i] = c.address;
            tbl_end[i] = e;
            tbl_uses[i] = 16'd1;
            done = 1'b1;
          end
        end
        if (!done) r.outcome = OUTC_UNCACHED;
      end
      MODE_REL: begin
        r.slot_out = c.slot;
        if (!c.handle_cached || int'(c.slot) >= n || !tbl_valid[c.slot]) begin
          r.outcome = OUTC_UNC_REL;
        end else if (tbl_uses[c.slot] == 16'd0) begin
          r.outcome = OUTC_UNDERFLOW;
        end else begin
          tbl_uses[c.slot]--;
          r.outcome = OUTC_RELEASED;
        end
      end
      default: begin
        inv = 0;
        busy = 0;
        for (int i = 0; i < n; i++) begin
          if (tbl_valid[i] && c.address < tbl_end[i] && tbl_start[i] < e) begin
            if (tbl_uses[i] == 16'd0) begin
              tbl_valid[i] = 1'b0;
              inv++;
            end else begin
              busy++;
            end
          end
        end
        r.outcome = OUTC_FREE_DONE;
        r.invalidated_count = inv[CNT_OUT_W-1:0];
        r.busy_count = busy[CNT_OUT_W-1:0];
      end
    endcase
    return r;
  endfunction

  // drive one command, predict on accept
  task automatic send_cmd(input cmd_t c, input logic chk, input rsp_t typed);
    int gap;
    rsp_t r;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.mode <= c.mode;
    req.address <= c.address;
    req.length <= c.length;
    req.slot <= c.slot;
    req.handle_cached <= c.handle_cached;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    if (c.mode != MODE_RSV) begin
      r = predict_table(c);
      pending_rsp.push_back(r);
      typed_rsp.push_back(typed);
      typed_chk.push_back(chk);
    end
  endtask

  task automatic write_slots(input logic [CFG_W-1:0] v);
    req.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.data <= v;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    cfg.valid <= 1'b0;
    slots_used = v;
  endtask

  function automatic cmd_t mk(input logic [1:0] m, input logic [47:0] a, input logic [31:0] l,
                              input logic [7:0] s, input logic h);
    cmd_t c;
    c.mode = m;
    c.address = a;
    c.length = l;
    c.slot = s;
    c.handle_cached = h;
    return c;
  endfunction

  function automatic rsp_t mkr(input logic [OUTC_W-1:0] o, input logic [7:0] s);
    rsp_t r;
    r = '0;
    r.outcome = o;
    r.slot_out = s;
    return r;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int k;
    k = $urandom_range(0, 99);
    c.address = {32'd0, 16'($urandom_range(0, 15)) << 8};
    if ($urandom_range(0, 19) == 0) c.address = {$urandom, 16'($urandom)};
    c.length = $urandom_range(0, 1023);
    if ($urandom_range(0, 19) == 0) c.length = $urandom;
    c.slot = 8'($urandom_range(0, 11));
    if ($urandom_range(0, 9) == 0) c.slot = 8'($urandom);
    c.handle_cached = ($urandom_range(0, 9) != 0);
    if (k < 45) c.mode = MODE_REG;
    else if (k < 80) c.mode = MODE_REL;
    else if (k < 97) c.mode = MODE_FREE;
    else c.mode = MODE_RSV;
    return c;
  endfunction

  // response side
  initial begin
    rsp_t got;
    rsp_t exp;
    rsp_t typ;
    logic chk;
    int gap;
    rsp.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp.valid) @(posedge clk_i);
      got.outcome = rsp.outcome;
      got.slot_out = rsp.slot_out;
      got.sub_offset = rsp.sub_offset;
      got.evict_valid = rsp.evict_valid;
      got.evicted_start = rsp.evicted_start;
      got.evicted_end = rsp.evicted_end;
      got.invalidated_count = rsp.invalidated_count;
      got.busy_count = rsp.busy_count;
      if (pending_rsp.size() == 0) begin
        report("unexpected", got, '0);
      end else begin
        exp = pending_rsp.pop_front();
        typ = typed_rsp.pop_front();
        chk = typed_chk.pop_front();
        if (chk && typ != exp) report("typed row", exp, typ);
        if (got.outcome != exp.outcome) report("outcome", got, exp);
        if (got.slot_out != exp.slot_out) report("slot_out", got, exp);
        if (got.sub_offset != exp.sub_offset) report("sub_offset", got, exp);
        if (got.evict_valid != exp.evict_valid) report("evict_valid", got, exp);
        if (got.evicted_start != exp.evicted_start) report("evicted_start", got, exp);
        if (got.evicted_end != exp.evicted_end) report("evicted_end", got, exp);
        if (got.invalidated_count != exp.invalidated_count) report("invalidated", got, exp);
        if (got.busy_count != exp.busy_count) report("busy_count", got, exp);
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    forever begin
      @(posedge clk_i);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    row_t rows[$];
    cmd_t c;
    req.valid <= 1'b0;
    req.mode <= MODE_REG;
    req.address <= '0;
    req.length <= '0;
    req.slot <= '0;
    req.handle_cached <= 1'b0;
    cfg.valid <= 1'b0;
    cfg.data <= '0;
    for (int i = 0; i < NSLOT; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_start[i] = '0;
      tbl_end[i] = '0;
      tbl_uses[i] = '0;
    end
    slots_used = NSLOT;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows.push_back('{mk(MODE_REL, 48'd0, 32'd0, 8'd0, 1'b1), 1'b1, mkr(OUTC_UNC_REL, 8'd0)});
    rows.push_back('{mk(MODE_REG, 48'h1000, 32'h100, 8'd0, 1'b0), 1'b1, mkr(OUTC_FILL, 8'd0)});
    rows.push_back('{mk(MODE_REG, 48'h1000, 32'h100, 8'd0, 1'b0), 1'b1, mkr(OUTC_HIT, 8'd0)});
    rows.push_back('{mk(MODE_REG, 48'h1010, 32'h10, 8'd0, 1'b0), 1'b0, '0});
    rows.push_back('{mk(MODE_REG, AMAX, 32'hFFFF_FFFF, 8'd0, 1'b1), 1'b1, mkr(OUTC_FILL, 8'd1)});
    rows.push_back('{mk(MODE_REG, 48'd0, 32'd0, 8'd0, 1'b0), 1'b1, mkr(OUTC_FILL, 8'd2)});
    rows.push_back('{mk(MODE_REL, 48'd0, 32'd0, 8'd0, 1'b1), 1'b0, '0});
    rows.push_back('{mk(MODE_REL, 48'd0, 32'd0, 8'd0, 1'b1), 1'b0, '0});
    rows.push_back('{mk(MODE_REL, 48'd0, 32'd0, 8'd0, 1'b1), 1'b0, '0});
    rows.push_back('{mk(MODE_REL, 48'd0, 32'd0, 8'd0, 1'b1), 1'b1, mkr(OUTC_UNDERFLOW, 8'd0)});
    rows.push_back('{mk(MODE_REL, 48'd0, 32'd0, 8'd1, 1'b0), 1'b1, mkr(OUTC_UNC_REL, 8'd1)});
    rows.push_back('{mk(MODE_REL, 48'd0, 32'd0, 8'hFF, 1'b1), 1'b1, mkr(OUTC_UNC_REL, 8'hFF)});
    rows.push_back('{mk(MODE_RSV, AMAX, 32'hFFFF_FFFF, 8'hFF, 1'b1), 1'b0, '0});
    rows.push_back('{mk(MODE_FREE, 48'h1010, 32'd0, 8'd0, 1'b0), 1'b0, '0});
    rows.push_back('{mk(MODE_FREE, 48'd0, 32'hFFFF_FFFF, 8'd0, 1'b0), 1'b0, '0});
    rows.push_back('{mk(MODE_REG, 48'h5555_AAAA_5555, 32'h5555_AAAA, 8'hAA, 1'b0), 1'b0, '0});
    foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].chk, rows[i].rsp);

    // replace and uncached with a tiny table
    write_slots(9'd1);
    send_cmd(mk(MODE_REL, 48'd0, 32'd0, 8'd0, 1'b1), 1'b0, '0);
    send_cmd(mk(MODE_REG, 48'h2000, 32'h40, 8'd0, 1'b0), 1'b0, '0);
    send_cmd(mk(MODE_REG, 48'h3000, 32'h40, 8'd0, 1'b0), 1'b1, mkr(OUTC_UNCACHED, 8'd0));
    send_cmd(mk(MODE_REL, 48'd0, 32'd0, 8'd1, 1'b1), 1'b1, mkr(OUTC_UNC_REL, 8'd1));

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_slots(9'd0);
        1: write_slots(9'd4);
        2: write_slots(9'd12);
        3: write_slots(9'h1FF);
        default: write_slots(9'd256);
      endcase
      for (int k = 0; k < 90; k++) begin
        c = rand_cmd();
        send_cmd(c, 1'b0, '0);
      end
    end
    req.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
